// ===== design/wris_pkg.sv =====
package wris_pkg;

    localparam int WEIGHT_W        = 16;
    localparam int RND_W           = 31;
    localparam int CHOSEN_W        = 4;
    localparam int DEF_MAX_WEIGHTS = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [RND_W-1:0]    random_value;
        logic                last_weight;
    } req_t;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_index;
        logic                list_overflowed;
    } rsp_t;

endpackage

// ===== design/wris_store.sv =====
module wris_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/wris_div.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module wris_div #(
    parameter int DVSR_W = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [wris_pkg::RND_W-1:0] dividend,
    input  logic [DVSR_W-1:0]        divisor,
    output logic                     done,
    output logic [DVSR_W-1:0]        remainder
);
    import wris_pkg::*;

    localparam int STEP_W = $clog2(RND_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0]  shift_reg, shift_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W:0]   trial;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        dvsr_next  = dvsr_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[RND_W-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = STEP_W'(RND_W);
            shift_next = dividend;
            dvsr_next  = divisor;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvsr_reg})
            begin
                rem_next = DVSR_W'(trial - {1'b0, dvsr_reg});
            end
            else
            begin
                rem_next = trial[DVSR_W-1:0];
            end
            shift_next = {shift_reg[RND_W-2:0], 1'b0};
            cnt_next   = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        dvsr_reg  <= dvsr_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/weighted_random_index_select_unit.sv =====
// Weighted random index select (roulette wheel).
// Request channel: start/busy with req (weight, random_value, last_weight).
//   A request is taken at a clock edge with start high and busy low.
//   Weights load one per cycle while busy is low; the store holds
//   MAX_WEIGHTS of them, further weights are dropped and flagged.
// The request marked last_weight raises busy: random_value is reduced
//   modulo the total (or modulo the count when all weights are zero) by a
//   bit-serial remainder unit; unless all weights are zero, the stored
//   weights are then scanned one per cycle from a registered-read memory.
// Result channel: done strobes high for one cycle with rsp (chosen_index,
//   list_overflowed). The receiver cannot stall; the result must be taken
//   in that cycle. busy is low again in the done cycle, so the next list
//   may start loading at once.
// After each result the list (count, total, overflow flag) is emptied.
// Reset (rst_n low) empties the list and aborts any selection in flight.
module weighted_random_index_select_unit #(
    parameter int MAX_WEIGHTS = wris_pkg::DEF_MAX_WEIGHTS,
    parameter int WEIGHT_BITS = wris_pkg::DEF_WEIGHT_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  wris_pkg::req_t req,
    output logic           done,
    output wris_pkg::rsp_t rsp
);
    import wris_pkg::*;

    localparam int W_EFF = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int IDX_W = $clog2(MAX_WEIGHTS);
    localparam int CNT_W = $clog2(MAX_WEIGHTS + 1);
    localparam int TOT_W = W_EFF + IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic                done_reg, done_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [TOT_W-1:0]    scan_rem_reg, scan_rem_next;
    logic                zero_reg, zero_next;
    logic [CHOSEN_W-1:0] index_reg, index_next;
    logic                flag_reg, flag_next;

    logic             accept;
    logic             full;
    logic             store_en;
    logic [W_EFF-1:0] w_in;
    logic [CNT_W-1:0] count_upd;
    logic [TOT_W-1:0] total_upd;
    logic             ovf_upd;
    logic             div_start;
    logic [TOT_W-1:0] divisor;
    logic             div_done;
    logic [TOT_W-1:0] div_rem;
    logic [W_EFF-1:0] rd_w;
    logic             hit;
    logic             last_idx;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start & ~busy;
    assign full     = (count_reg == CNT_W'(MAX_WEIGHTS));
    assign store_en = accept & ~full;
    assign w_in     = req.weight[W_EFF-1:0];
    assign count_upd = store_en ? count_reg + CNT_W'(1) : count_reg;
    assign total_upd = store_en ? total_reg + TOT_W'(w_in) : total_reg;
    assign ovf_upd   = ovf_reg | (accept & full);
    assign divisor   = (total_upd != '0) ? total_upd : TOT_W'(count_upd);
    assign hit       = scan_rem_reg < TOT_W'(rd_w);
    assign last_idx  = (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1));

    wris_store #(
        .DEPTH  (MAX_WEIGHTS),
        .DATA_W (W_EFF)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (w_in),
        .rd_addr (scan_idx_next),
        .rd_data (rd_w)
    );

    wris_div #(
        .DVSR_W (TOT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.random_value),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        done_next     = 1'b0;
        scan_idx_next = scan_idx_reg;
        scan_rem_next = scan_rem_reg;
        zero_next     = zero_reg;
        index_next    = index_reg;
        flag_next     = flag_reg;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_upd;
                    total_next = total_upd;
                    ovf_next   = ovf_upd;
                    if (req.last_weight)
                    begin
                        zero_next     = (total_upd == '0);
                        div_start     = 1'b1;
                        scan_idx_next = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (zero_reg)
                    begin
                        done_next  = 1'b1;
                        index_next = CHOSEN_W'(div_rem);
                        flag_next  = ovf_reg;
                        count_next = '0;
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_rem_next = div_rem;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit || last_idx)
                begin
                    done_next  = 1'b1;
                    index_next = hit ? CHOSEN_W'(scan_idx_reg) : '0;
                    flag_next  = ovf_reg;
                    count_next = '0;
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_rem_next = scan_rem_reg - TOT_W'(rd_w);
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        scan_rem_reg <= scan_rem_next;
        zero_reg     <= zero_next;
        index_reg    <= index_next;
        flag_reg     <= flag_next;
    end

    assign done                = done_reg;
    assign rsp.chosen_index    = index_reg;
    assign rsp.list_overflowed = flag_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a selection in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.last_weight |=> busy && count_reg != '0)
        else $error("last request did not start a selection");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_WEIGHTS))
        else $error("weight count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> CNT_W'(scan_idx_reg) < count_reg)
        else $error("scan ran past the stored weights");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> count_reg == '0 || $past(start))
        else $error("list not emptied after result");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import wris_pkg::*;

    localparam int SLOTS           = DEF_MAX_WEIGHTS;
    localparam int WATCHDOG_CYCLES = 1000;
    localparam int DIR_ROWS        = 24;

    typedef enum int {FLAT_ZERO, FULL_SCALE, SPARSE, LIGHT} list_kind_e;

    typedef struct packed {
        req_t rq;
        logic pinned;
        rsp_t rs;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // typed expectation that travels with a directed request
    logic pin_valid;
    rsp_t pin_rsp;

    logic [WEIGHT_W-1:0] wheel_weights [SLOTS];
    logic [19:0]         wheel_total;
    logic [4:0]          wheel_count;
    logic                wheel_dropped;

    rsp_t     pending_picks [$];
    dir_row_t dir_table [DIR_ROWS];

    int sent           = 0;
    int lists_done     = 0;
    int overflow_lists = 0;
    int zero_lists     = 0;
    int picks_checked  = 0;
    int mismatches     = 0;
    int idle_run       = 0;

    weighted_random_index_select_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    function automatic void roulette_step(input req_t r, output logic fired, output rsp_t pick);
        logic [RND_W-1:0] rem;
        logic             found;
        fired = 1'b0;
        pick  = '0;
        if (wheel_count < SLOTS) begin
            wheel_weights[wheel_count] = r.weight;
            wheel_count                = wheel_count + 5'd1;
            wheel_total                = wheel_total + 20'(r.weight);
        end else begin
            wheel_dropped = 1'b1;
        end
        if (r.last_weight) begin
            fired                = 1'b1;
            pick.list_overflowed = wheel_dropped;
            if (wheel_count != 0) begin
                if (wheel_total == 0) begin
                    pick.chosen_index = CHOSEN_W'(r.random_value % wheel_count);
                end else begin
                    rem   = r.random_value % wheel_total;
                    found = 1'b0;
                    for (int i = 0; i < wheel_count; i++) begin
                        if (!found) begin
                            if (rem < wheel_weights[i]) begin
                                pick.chosen_index = CHOSEN_W'(i);
                                found             = 1'b1;
                            end else begin
                                rem = rem - wheel_weights[i];
                            end
                        end
                    end
                end
            end
            lists_done++;
            if (wheel_dropped)
                overflow_lists++;
            if (wheel_total == 0)
                zero_lists++;
            wheel_total   = '0;
            wheel_count   = '0;
            wheel_dropped = 1'b0;
        end
    endfunction

    task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected index %0d ovf %0b, got index %0d ovf %0b", $realtime,
                     what, want.chosen_index, want.list_overflowed,
                     got.chosen_index, got.list_overflowed);
    endtask

    always @(posedge clk) begin
        logic fired;
        logic moved;
        rsp_t pick;
        rsp_t want;
        if (rst_n) begin
            moved = 1'b0;
            if (done) begin
                moved = 1'b1;
                if (pending_picks.size() == 0) begin
                    flag_mismatch("unexpected result", '0, rsp);
                end else begin
                    want = pending_picks.pop_front();
                    picks_checked++;
                    if (rsp.chosen_index !== want.chosen_index ||
                        rsp.list_overflowed !== want.list_overflowed)
                        flag_mismatch("result mismatch", want, rsp);
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                roulette_step(req, fired, pick);
                if (fired) begin
                    want          = pin_valid ? pin_rsp : pick;
                    pending_picks = {pending_picks, want};
                end
            end
            idle_run = moved ? 0 : idle_run + 1;
            if (idle_run >= WATCHDOG_CYCLES) begin
                $display("watchdog: no request or result for %0d cycles", WATCHDOG_CYCLES);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic drive(input req_t r, input logic pinned, input rsp_t pin_val,
                         input int idle_pct);
        logic [63:0] noise;
        start     <= 1'b1;
        req       <= r;
        pin_valid <= pinned;
        pin_rsp   <= pin_val;
        do @(posedge clk); while (busy);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            noise = {$urandom, $urandom};
            start <= 1'b0;
            req   <= noise[47:0];
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_picks();
        start <= 1'b0;
        @(negedge clk);
        while (pending_picks.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic run_list(input int idle_pct);
        int         roll;
        int         len;
        list_kind_e kind;
        req_t       r;
        roll = $urandom_range(99);
        if (roll < 8)
            len = $urandom_range(SLOTS + 1, SLOTS + 4);
        else if (roll < 15)
            len = SLOTS;
        else if (roll < 60)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(5, SLOTS - 1);
        kind = list_kind_e'($urandom_range(LIGHT + 2));
        if (kind > LIGHT)
            kind = LIGHT;
        for (int i = 0; i < len; i++) begin
            r.random_value = RND_W'($urandom);
            case (kind)
                FLAT_ZERO:  r.weight = '0;
                FULL_SCALE: r.weight = WEIGHT_W'($urandom);
                SPARSE:     r.weight = ($urandom_range(2) == 0) ? '0 :
                                       WEIGHT_W'($urandom_range(1, 9));
                default:    r.weight = WEIGHT_W'($urandom_range(0, 300));
            endcase
            r.last_weight = (i == len - 1);
            if (r.last_weight && $urandom_range(4) == 0)
                r.random_value = $urandom_range(1) ? 31'h7FFF_FFFF : 31'h0;
            drive(r, 1'b0, '0, idle_pct);
        end
    endtask

    initial begin
        int target;
        int idle_pct;
        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        pin_valid     = 1'b0;
        pin_rsp       = '0;
        wheel_total   = '0;
        wheel_count   = '0;
        wheel_dropped = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            wheel_weights[i] = '0;

        dir_table = '{
            '{'{16'h0000, 31'h0000_0000, 1'b1}, 1'b1, '{4'd0, 1'b0}},
            '{'{16'hFFFF, 31'h7FFF_FFFF, 1'b1}, 1'b1, '{4'd0, 1'b0}},
            // zero weight inside a list
            '{'{16'h0005, 31'h1234_5678, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0000, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0003, 31'h0000_0007, 1'b1}, 1'b0, '{4'd0, 1'b0}},
            // all-zero list: index from random modulo count
            '{'{16'h0000, 31'h5555_5555, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0000, 31'h7FFF_FFFF, 1'b1}, 1'b0, '{4'd0, 1'b0}},
            // full store, then a dropped last weight
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'h0001, 31'h0000_0000, 1'b0}, 1'b0, '{4'd0, 1'b0}},
            '{'{16'hA5A5, 31'h0000_000F, 1'b1}, 1'b1, '{4'd15, 1'b1}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            drive(dir_table[k].rq, dir_table[k].pinned, dir_table[k].rs, 36);
        drain_picks();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 36 : (phase == 1) ? 58 : 0;
            target   = sent + 425;
            while (sent < target)
                run_list(idle_pct);
            drain_picks();
        end

        repeat (60) @(posedge clk);

        $display("Sent %0d weight requests in %0d lists; %0d results checked.",
                 sent, lists_done, picks_checked);
        $display("Lists with dropped weights: %0d, lists with zero total: %0d.",
                 overflow_lists, zero_lists);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== weighted_random_index_select_unit.f =====
design/wris_pkg.sv
design/wris_store.sv
design/wris_div.sv
design/weighted_random_index_select_unit.sv
tb/testbench.sv
